[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the decoder.
// Depends on nothing; the asserting module must have i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define QPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define QPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/qpd_pkg.sv]
// Package of the quoted-printable decoder: types, character codes and helpers.
// Used by every module of the decoder; depends on nothing.
package qpd_pkg;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_EQ   = 2'd1,
        PH_HELD = 2'd2
    } t_phase;

    // Up to three decoded bytes caused by one input word, in order from slot 0.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } t_group;

    function automatic logic is_keep(input logic [7:0] b);
        is_keep = (b >= 8'h20 && b <= 8'h7E) || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
                 (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b <= 8'h46) begin
            v = b - 8'h37;
        end else begin
            v = b - 8'h57;
        end
        hex_val = v[3:0];
    endfunction

endpackage

[rtl/qpd_front.sv]
// Front part: accepts encoded bytes, runs the escape state machine and
// classifies each word into a group of decoded bytes. Depends on qpd_pkg.
module qpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data,
    input  logic            i_eom,
    input  logic            i_space,
    output logic            o_ready,
    output logic            o_push,
    output qpd_pkg::t_group o_group
);
    import qpd_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       w_accept;
    logic       w_crlf;
    logic       w_hex;
    logic       w_keep_c1;
    logic       w_keep_b;

    assign w_accept  = i_valid && i_space;
    assign o_ready   = i_space;
    assign w_crlf    = (r_held == CH_CR) && (i_data == CH_LF);
    assign w_hex     = is_hex(r_held) && is_hex(i_data);
    assign w_keep_c1 = is_keep(r_held);
    assign w_keep_b  = (i_data != CH_EQUALS) && is_keep(i_data);

    always_comb begin
        n_phase = PH_IDLE;
        n_held  = r_held;
        case (r_phase)
            PH_EQ: begin
                if (i_data != CH_LF) begin
                    n_held  = i_data;
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                if (w_crlf || w_hex) begin
                    n_phase = PH_IDLE;
                end else if (r_held == CH_EQUALS) begin
                    if (i_data != CH_LF) begin
                        n_held  = i_data;
                        n_phase = PH_HELD;
                    end
                end else if (i_data == CH_EQUALS) begin
                    n_phase = PH_EQ;
                end
            end
            default: begin
                if (i_data == CH_EQUALS) begin
                    n_phase = PH_EQ;
                end
            end
        endcase
        if (i_eom) begin
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        o_group.count    = 2'd0;
        o_group.bytes[0] = i_data;
        o_group.bytes[1] = i_data;
        o_group.bytes[2] = i_data;
        case (r_phase)
            PH_EQ: begin
                o_group.count = 2'd0;
            end
            PH_HELD: begin
                if (w_crlf) begin
                    o_group.count = 2'd0;
                end else if (w_hex) begin
                    o_group.count    = 2'd1;
                    o_group.bytes[0] = {hex_val(r_held), hex_val(i_data)};
                end else if (r_held == CH_EQUALS) begin
                    o_group.count    = 2'd1;
                    o_group.bytes[0] = CH_EQUALS;
                end else begin
                    o_group.bytes[0] = CH_EQUALS;
                    o_group.bytes[1] = w_keep_c1 ? r_held : i_data;
                    o_group.count    = 2'd1 + {1'b0, w_keep_c1} + {1'b0, w_keep_b};
                end
            end
            default: begin
                o_group.count = {1'b0, w_keep_b};
            end
        endcase
    end

    assign o_push = w_accept && (o_group.count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

[rtl/qpd_queue.sv]
// Short queue of decoded byte groups between the front and back parts.
// Depends on qpd_pkg.
module qpd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qpd_pkg::t_group i_group,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output qpd_pkg::t_group o_head
);
    import qpd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/qpd_back.sv]
// Back part: sends the bytes of the group at the queue head one word at a
// time and marks the last byte of each group. Depends on qpd_pkg.
module qpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  qpd_pkg::t_group i_head,
    output logic            o_pop,
    output logic            o_valid,
    output logic [7:0]      o_data,
    output logic            o_last,
    input  logic            i_ready
);
    import qpd_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       w_send;

    assign o_valid = !i_empty;
    assign o_data  = i_head.bytes[r_idx];
    assign o_last  = r_idx == (i_head.count - 2'd1);
    assign w_send  = o_valid && i_ready;
    assign o_pop   = w_send && o_last;

    always_comb begin
        n_idx = r_idx;
        if (w_send) begin
            n_idx = o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

[rtl/quoted_printable_decoder_top.sv]
// Quoted-printable decoder: one encoded byte in per word, zero to three decoded bytes out.
// Decoded bytes of an accepted word are registered in the group queue before being offered.
// Throughput: one input word per cycle while the queue has space; the output sends one byte
// per cycle while the sink is ready; the QUEUE_DEPTH group queue absorbs multi-byte words.
// Reset (synchronous, active low) empties the queue and clears any pending escape.
// Depends on qpd_pkg, qpd_front, qpd_queue and qpd_back.
module quoted_printable_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // end_of_message
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast    // run_last
);
    import qpd_pkg::*;

    t_group w_push_group;
    t_group w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    qpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_eom   (i_s_tlast),
        .i_space (!w_full),
        .o_ready (o_s_tready),
        .o_push  (w_push),
        .o_group (w_push_group)
    );

    qpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_group (w_push_group),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    qpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast),
        .i_ready (i_m_tready)
    );

endmodule

[rtl/qpd_checker.sv]
// Port-level checker of the quoted-printable decoder, bound to the top level.
// Depends on assert_macros.svh and quoted_printable_decoder_top.
`include "assert_macros.svh"

module qpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A waiting output word stays until it is taken.
    `QPD_ASSERT(a_out_valid_holds, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "output word withdrawn")
    `QPD_ASSERT(a_out_data_holds, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast), "stalled output word changed")
    // Nothing is offered in the first cycle after reset.
    `QPD_ASSERT(a_empty_after_reset, !$past(i_rst_n) |-> !o_m_tvalid, "output word offered right after reset")
    // With nothing waiting on the output, the input side must not stall.
    `QPD_ASSERT(a_ready_when_drained, !o_m_tvalid |-> o_s_tready, "input stalled with output drained")

endmodule

bind quoted_printable_decoder_top qpd_checker u_qpd_checker (.*);
